// File: design/utf16_to_utf8_json_escaper_defines.svh
// assertion helpers shared by the escaper modules
`ifndef UTF16_TO_UTF8_JSON_ESCAPER_DEFINES_SVH
`define UTF16_TO_UTF8_JSON_ESCAPER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define U2J_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked outside reset
`define U2J_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/u2j_pkg.sv
`default_nettype none
package u2j_pkg;

  localparam int MaxBytes = 9;
  localparam int CountW   = 4;
  localparam int CpW      = 21;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    byte_t [MaxBytes-1:0] bytes;
    logic  [CountW-1:0]   count;
  } burst_t;

  localparam logic [15:0] HighFirst = 16'hD800;
  localparam logic [15:0] HighLast  = 16'hDBFF;
  localparam logic [15:0] LowFirst  = 16'hDC00;
  localparam logic [15:0] LowLast   = 16'hDFFF;

  localparam logic [CpW-1:0] SuppBase    = 21'h010000;
  localparam logic [CpW-1:0] Replacement = 21'h00FFFD;
  localparam logic [CpW-1:0] CtrlLimit   = 21'h000020;
  localparam logic [CpW-1:0] OneByteLim  = 21'h000080;
  localparam logic [CpW-1:0] TwoByteLim  = 21'h000800;
  localparam logic [CpW-1:0] BmpLim      = 21'h010000;

  localparam byte_t ChQuote     = 8'h22;
  localparam byte_t ChBackslash = 8'h5C;
  localparam byte_t ChZero      = 8'h30;
  localparam byte_t ChOne       = 8'h31;
  localparam byte_t ChB         = 8'h62;
  localparam byte_t ChF         = 8'h66;
  localparam byte_t ChN         = 8'h6E;
  localparam byte_t ChR         = 8'h72;
  localparam byte_t ChT         = 8'h74;
  localparam byte_t ChU         = 8'h75;

  localparam byte_t RepByte0 = 8'hEF;
  localparam byte_t RepByte1 = 8'hBF;
  localparam byte_t RepByte2 = 8'hBD;

  // uppercase hex digit for one nibble
  function automatic byte_t hex_digit(input logic [3:0] n);
    byte_t d;
    if (n < 4'd10) begin
      d = 8'h30 + {4'h0, n};
    end else begin
      d = 8'h37 + {4'h0, n};
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// File: design/u2j_in_if.sv
`default_nettype none
interface u2j_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        last_unit;

  modport source (output valid, code_unit, last_unit, input ready);
  modport sink   (input valid, code_unit, last_unit, output ready);
endinterface
`default_nettype wire

// File: design/u2j_out_if.sv
`default_nettype none
interface u2j_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;

  modport source (output valid, out_byte, run_end, input ready);
  modport sink   (input valid, out_byte, run_end, output ready);
endinterface
`default_nettype wire

// File: design/u2j_encoder.sv
`default_nettype none
`include "utf16_to_utf8_json_escaper_defines.svh"
module u2j_encoder (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [15:0]     code_unit,
  input  wire logic            last_unit,
  output u2j_pkg::burst_t      burst
);

  logic [9:0] held_high;
  logic       held_valid;

  logic                     is_high;
  logic                     is_low;
  logic                     flush;
  logic                     emit_cp;
  logic [u2j_pkg::CpW-1:0]  cp;
  u2j_pkg::byte_t [5:0]     cb;
  logic [2:0]               clen;

  assign is_high = (code_unit >= u2j_pkg::HighFirst) && (code_unit <= u2j_pkg::HighLast);
  assign is_low  = (code_unit >= u2j_pkg::LowFirst) && (code_unit <= u2j_pkg::LowLast);
  // a held high surrogate that finds no low partner goes out as a replacement first
  assign flush   = held_valid && !is_low;
  assign emit_cp = !(is_high && !last_unit);

  always_comb begin
    if (held_valid && is_low) begin
      cp = u2j_pkg::SuppBase + {1'b0, held_high, code_unit[9:0]};
    end else if (is_high || is_low) begin
      cp = u2j_pkg::Replacement;
    end else begin
      cp = {5'b0, code_unit};
    end
  end

  always_comb begin
    cb   = '0;
    clen = 3'd0;
    priority if (cp == {13'b0, u2j_pkg::ChQuote}) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChQuote; clen = 3'd2;
    end else if (cp == {13'b0, u2j_pkg::ChBackslash}) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChBackslash; clen = 3'd2;
    end else if (cp == 21'h08) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChB; clen = 3'd2;
    end else if (cp == 21'h0C) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChF; clen = 3'd2;
    end else if (cp == 21'h0A) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChN; clen = 3'd2;
    end else if (cp == 21'h0D) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChR; clen = 3'd2;
    end else if (cp == 21'h09) begin
      cb[0] = u2j_pkg::ChBackslash; cb[1] = u2j_pkg::ChT; clen = 3'd2;
    end else if (cp < u2j_pkg::CtrlLimit) begin
      // other controls as \u00XX
      cb[0] = u2j_pkg::ChBackslash;
      cb[1] = u2j_pkg::ChU;
      cb[2] = u2j_pkg::ChZero;
      cb[3] = u2j_pkg::ChZero;
      cb[4] = cp[4] ? u2j_pkg::ChOne : u2j_pkg::ChZero;
      cb[5] = u2j_pkg::hex_digit(cp[3:0]);
      clen  = 3'd6;
    end else if (cp < u2j_pkg::OneByteLim) begin
      cb[0] = cp[7:0]; clen = 3'd1;
    end else if (cp < u2j_pkg::TwoByteLim) begin
      cb[0] = {3'b110, cp[10:6]};
      cb[1] = {2'b10, cp[5:0]};
      clen  = 3'd2;
    end else if (cp < u2j_pkg::BmpLim) begin
      cb[0] = {4'b1110, cp[15:12]};
      cb[1] = {2'b10, cp[11:6]};
      cb[2] = {2'b10, cp[5:0]};
      clen  = 3'd3;
    end else begin
      cb[0] = {5'b11110, cp[20:18]};
      cb[1] = {2'b10, cp[17:12]};
      cb[2] = {2'b10, cp[11:6]};
      cb[3] = {2'b10, cp[5:0]};
      clen  = 3'd4;
    end
  end

  always_comb begin
    burst = '0;
    if (flush) begin
      burst.bytes[0] = u2j_pkg::RepByte0;
      burst.bytes[1] = u2j_pkg::RepByte1;
      burst.bytes[2] = u2j_pkg::RepByte2;
      for (int i = 0; i < 6; i++) begin
        burst.bytes[i+3] = emit_cp ? cb[i] : 8'h00;
      end
      burst.count = 4'd3 + (emit_cp ? {1'b0, clen} : 4'd0);
    end else begin
      for (int i = 0; i < 6; i++) begin
        burst.bytes[i] = cb[i];
      end
      burst.count = emit_cp ? {1'b0, clen} : 4'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_high  <= '0;
    end else if (accept) begin
      if (is_high && !last_unit) begin
        held_valid <= 1'b1;
        held_high  <= code_unit[9:0];
      end else begin
        held_valid <= 1'b0;
        held_high  <= '0;
      end
    end
  end

  `U2J_ASSERT_NOW(a_silent_only_when_holding, accept && (burst.count == 4'd0), is_high && !last_unit && !held_valid)
  `U2J_ASSERT_NEXT(a_last_clears_hold, accept && last_unit, !held_valid)

endmodule
`default_nettype wire

// File: design/u2j_serializer.sv
`default_nettype none
`include "utf16_to_utf8_json_escaper_defines.svh"
module u2j_serializer (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            load,
  input  wire u2j_pkg::burst_t burst,
  output logic                 can_load,
  u2j_out_if.source            byte_out
);

  logic                       busy;
  u2j_pkg::burst_t            burst_q;
  logic [u2j_pkg::CountW-1:0] idx;
  logic                       take;
  logic                       at_end;

  assign at_end            = (idx == (burst_q.count - 4'd1));
  assign take              = busy && byte_out.ready;
  assign can_load          = !busy || (take && at_end);
  assign byte_out.valid    = busy;
  assign byte_out.out_byte = burst_q.bytes[idx];
  assign byte_out.run_end  = at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy    <= 1'b1;
      idx     <= '0;
      burst_q <= burst;
    end else if (take) begin
      if (at_end) begin
        busy <= 1'b0;
        idx  <= '0;
      end else begin
        idx <= idx + 4'd1;
      end
    end
  end

  `U2J_ASSERT_NOW(a_index_in_burst, busy, (idx < burst_q.count) && (burst_q.count != 4'd0))
  `U2J_ASSERT_NOW(a_load_only_when_free, load, can_load && (burst.count != 4'd0))
  `U2J_ASSERT_NEXT(a_step_advances, take && !at_end && !load, busy && (idx == $past(idx) + 4'd1))

endmodule
`default_nettype wire

// File: design/utf16_to_utf8_json_escaper.sv
// channel   dir  payload                         handshake
// unit_in   in   code_unit[15:0], last_unit      valid/ready
// byte_out  out  out_byte[7:0], run_end          valid/ready
//
// a unit is encoded in the cycle it is accepted; its bytes leave one per cycle
// from the burst register while byte_out is ready, up to 9 bytes per unit
// a held high surrogate yields no bytes
// the next unit is taken in the cycle the last byte of the burst is taken
// rst is synchronous and clears the held surrogate and the serializer busy flag and index
// a stall on byte_out holds the current byte and blocks unit_in
`default_nettype none
module utf16_to_utf8_json_escaper (
  input  wire logic clk,
  input  wire logic rst,
  u2j_in_if.sink    unit_in,
  u2j_out_if.source byte_out
);

  u2j_pkg::burst_t burst;
  logic            can_load;
  logic            accept;
  logic            load;

  assign unit_in.ready = can_load;
  assign accept        = unit_in.valid && can_load;
  assign load          = accept && (burst.count != 4'd0);

  u2j_encoder u_encoder (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .code_unit (unit_in.code_unit),
    .last_unit (unit_in.last_unit),
    .burst     (burst)
  );

  u2j_serializer u_serializer (
    .clk      (clk),
    .rst      (rst),
    .load     (load),
    .burst    (burst),
    .can_load (can_load),
    .byte_out (byte_out)
  );

endmodule
`default_nettype wire
